// ===== rtl/bvmm_pkg.sv =====
// Shared types, widths and codes of the block vector-matrix multiply core.
package bvmm_pkg;

	localparam int FUNC_W     = 2;
	localparam int ROW_W      = 8;
	localparam int COL_W      = 3;
	localparam int VALUE_W    = 32;
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 32;
	localparam int M_TUSER_W  = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int USED_ROWS_W = 9;
	localparam int USED_COLS_W = 4;
	localparam int LEN_W      = 9;
	localparam int PROD_W     = 2 * VALUE_W;
	localparam int ACC_W      = PROD_W + LEN_W;
	localparam int FRAC_W     = 16;

	localparam int DEF_MAX_ROWS       = 256;
	localparam int DEF_MAX_COLS       = 8;
	localparam int DEF_MAX_RIGHT_COLS = 8;

	localparam logic [USED_ROWS_W-1:0] USED_ROWS_RST = 9'd256;
	localparam logic [USED_COLS_W-1:0] USED_COLS_RST = 4'd8;

	localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USED_ROWS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_USED_COLS = 2'd2;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD_LEFT  = 2'd0,
		FUNC_LOAD_RIGHT = 2'd1,
		FUNC_COMPUTE    = 2'd2,
		FUNC_RESERVED   = 2'd3
	} bvmm_func_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic load_out;
		logic err;
		logic transpose;
		logic wr_left;
		logic wr_right;
	} bvmm_cmd_t;

	typedef struct packed {
		logic busy;
	} bvmm_status_t;

endpackage

// ===== rtl/block_vector_matrix_multiply_core.sv =====
// Top level of the block vector-matrix multiply core: stream ports, controller and datapath.
// Load items keep input ready; the next item can be accepted in the following cycle.
// A compute item streams len elements through one multiply-accumulate unit, one per cycle,
// len = used_cols (normal) or used_rows (transposed), limited by the sizes of the stores.
// A compute goes through RUN (skipped for len 0), DRAIN and FINISH; FINISH holds while a result waits unread.
// An out-of-range request goes straight to FINISH for an index-error result; input reopens with it.
// Asynchronous active-low reset clears the controller and pipeline valid bits; the stores and data registers are not.
module block_vector_matrix_multiply_core #(
	parameter int MAX_ROWS       = bvmm_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS       = bvmm_pkg::DEF_MAX_COLS,
	parameter int MAX_RIGHT_COLS = bvmm_pkg::DEF_MAX_RIGHT_COLS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [bvmm_pkg::S_TDATA_W-1:0]      s_tdata,  // row_index[7:0], col_index[10:8], value[42:11]
	input  logic [bvmm_pkg::FUNC_W-1:0]         s_tuser,  // func[1:0]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [bvmm_pkg::M_TDATA_W-1:0]      m_tdata,  // product_value[31:0]
	output logic [bvmm_pkg::M_TUSER_W-1:0]      m_tuser,  // saturated[0], index_error[1]
	input  logic                                cfg_we,
	input  logic [bvmm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bvmm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int ROW_W   = bvmm_pkg::ROW_W;
	localparam int COL_W   = bvmm_pkg::COL_W;
	localparam int VALUE_W = bvmm_pkg::VALUE_W;

	logic [ROW_W-1:0]        row;
	logic [COL_W-1:0]        col;
	logic [VALUE_W-1:0]      value;
	logic [VALUE_W-1:0]      product_value;
	logic                    saturated;
	logic                    index_error;
	bvmm_pkg::bvmm_cmd_t     cmd;
	bvmm_pkg::bvmm_status_t  status;

	assign row   = s_tdata[ROW_W-1:0];
	assign col   = s_tdata[ROW_W+COL_W-1:ROW_W];
	assign value = s_tdata[ROW_W+COL_W+VALUE_W-1:ROW_W+COL_W];

	assign m_tdata = product_value;
	assign m_tuser = {index_error, saturated};

	bvmm_ctrl #(
		.MAX_ROWS       (MAX_ROWS),
		.MAX_COLS       (MAX_COLS),
		.MAX_RIGHT_COLS (MAX_RIGHT_COLS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.func      (s_tuser),
		.row       (row),
		.col       (col),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status)
	);

	bvmm_datapath #(
		.MAX_ROWS       (MAX_ROWS),
		.MAX_COLS       (MAX_COLS),
		.MAX_RIGHT_COLS (MAX_RIGHT_COLS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.row           (row),
		.col           (col),
		.value         (value),
		.product_value (product_value),
		.saturated     (saturated),
		.index_error   (index_error)
	);

endmodule

// ===== rtl/bvmm_datapath.sv =====
// Matrix stores, multiply-accumulate pipeline, saturation and result register.
module bvmm_datapath #(
	parameter int MAX_ROWS       = bvmm_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS       = bvmm_pkg::DEF_MAX_COLS,
	parameter int MAX_RIGHT_COLS = bvmm_pkg::DEF_MAX_RIGHT_COLS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bvmm_pkg::bvmm_cmd_t                cmd,
	output bvmm_pkg::bvmm_status_t             status,
	input  logic [bvmm_pkg::ROW_W-1:0]         row,
	input  logic [bvmm_pkg::COL_W-1:0]         col,
	input  logic [bvmm_pkg::VALUE_W-1:0]       value,
	output logic [bvmm_pkg::VALUE_W-1:0]       product_value,
	output logic                               saturated,
	output logic                               index_error
);

	localparam int RIGHT_ROWS  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int LEFT_DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int RIGHT_DEPTH = RIGHT_ROWS * MAX_RIGHT_COLS;
	localparam int LA_W = (LEFT_DEPTH > 1) ? $clog2(LEFT_DEPTH) : 1;
	localparam int RA_W = (RIGHT_DEPTH > 1) ? $clog2(RIGHT_DEPTH) : 1;
	localparam int ACC_W  = bvmm_pkg::ACC_W;
	localparam int FRAC_W = bvmm_pkg::FRAC_W;
	localparam int VALUE_W = bvmm_pkg::VALUE_W;

	logic [VALUE_W-1:0] left_mem  [LEFT_DEPTH];
	logic [VALUE_W-1:0] right_mem [RIGHT_DEPTH];

	logic [LA_W-1:0] la_q;
	logic [RA_W-1:0] ra_q;
	logic [LA_W-1:0] la_step_q;
	logic [LA_W-1:0] left_wr_addr;
	logic [RA_W-1:0] right_wr_addr;
	logic            left_in_range;
	logic            right_in_range;

	logic signed [VALUE_W-1:0]            a_s1;
	logic signed [VALUE_W-1:0]            b_s1;
	logic                                 v_s1;
	logic signed [bvmm_pkg::PROD_W-1:0]   prod_s2;
	logic                                 v_s2;
	logic signed [ACC_W-1:0]              acc_q;

	logic                                 fits;
	logic [VALUE_W-1:0]                   sat_value;

	assign left_in_range  = (int'(row) < MAX_ROWS) && (int'(col) < MAX_COLS);
	assign right_in_range = (int'(row) < RIGHT_ROWS) && (int'(col) < MAX_RIGHT_COLS);
	assign left_wr_addr   = LA_W'(int'(col) * MAX_ROWS + int'(row));
	assign right_wr_addr  = RA_W'(int'(col) * RIGHT_ROWS + int'(row));

	always_ff @(posedge clk) begin
		if (cmd.wr_left && left_in_range) begin
			left_mem[left_wr_addr] <= value;
		end
		if (cmd.wr_right && right_in_range) begin
			right_mem[right_wr_addr] <= value;
		end
		a_s1 <= left_mem[la_q];
		b_s1 <= right_mem[ra_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			if (cmd.transpose) begin
				la_q      <= LA_W'(int'(row) * MAX_ROWS);
				la_step_q <= LA_W'(1);
			end else begin
				la_q      <= LA_W'(int'(row));
				la_step_q <= LA_W'(MAX_ROWS);
			end
			ra_q <= RA_W'(int'(col) * RIGHT_ROWS);
		end else if (cmd.issue) begin
			la_q <= la_q + la_step_q;
			ra_q <= ra_q + RA_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * b_s1;
		if (cmd.start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign status.busy = v_s1 || v_s2;

	assign fits = (acc_q[ACC_W-1:FRAC_W+VALUE_W-1] == '0) ||
		(acc_q[ACC_W-1:FRAC_W+VALUE_W-1] == '1);
	assign sat_value = fits ? acc_q[FRAC_W+VALUE_W-1:FRAC_W] :
		(acc_q[ACC_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}});

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (cmd.err) begin
				product_value <= '0;
				saturated     <= 1'b0;
				index_error   <= 1'b1;
			end else begin
				product_value <= sat_value;
				saturated     <= !fits;
				index_error   <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/bvmm_ctrl.sv =====
// Controller: configuration registers, request check, sequencing and output valid.
module bvmm_ctrl #(
	parameter int MAX_ROWS       = bvmm_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS       = bvmm_pkg::DEF_MAX_COLS,
	parameter int MAX_RIGHT_COLS = bvmm_pkg::DEF_MAX_RIGHT_COLS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [bvmm_pkg::FUNC_W-1:0]          func,
	input  logic [bvmm_pkg::ROW_W-1:0]           row,
	input  logic [bvmm_pkg::COL_W-1:0]           col,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic                                 cfg_we,
	input  logic [bvmm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bvmm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output bvmm_pkg::bvmm_cmd_t                  cmd,
	input  bvmm_pkg::bvmm_status_t               status
);

	localparam int LEN_W = bvmm_pkg::LEN_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t                             state_q;
	logic                               tm_q;
	logic [bvmm_pkg::USED_ROWS_W-1:0]   used_rows_q;
	logic [bvmm_pkg::USED_COLS_W-1:0]   used_cols_q;
	logic [LEN_W-1:0]                   remain_q;
	logic                               err_q;
	logic                               out_valid_q;

	logic [bvmm_pkg::USED_ROWS_W-1:0]   rows_eff;
	logic [bvmm_pkg::USED_COLS_W-1:0]   cols_eff;
	logic [LEN_W-1:0]                   limit;
	logic [LEN_W-1:0]                   len;
	logic                               req_err;
	logic                               accept;
	logic                               is_compute;
	logic                               load_out;

	assign rows_eff = (int'(used_rows_q) > MAX_ROWS) ?
		bvmm_pkg::USED_ROWS_W'(MAX_ROWS) : used_rows_q;
	assign cols_eff = (int'(used_cols_q) > MAX_COLS) ?
		bvmm_pkg::USED_COLS_W'(MAX_COLS) : used_cols_q;
	assign limit    = tm_q ? LEN_W'(cols_eff) : LEN_W'(rows_eff);
	assign len      = tm_q ? LEN_W'(rows_eff) : LEN_W'(cols_eff);
	assign req_err  = (int'(col) >= MAX_RIGHT_COLS) || (LEN_W'(row) >= limit);

	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign is_compute = (func == bvmm_pkg::FUNC_COMPUTE);
	assign load_out   = (state_q == ST_FINISH) && (!out_valid_q || m_tready);
	assign m_tvalid   = out_valid_q;

	assign cmd.start     = accept && is_compute && !req_err;
	assign cmd.issue     = (state_q == ST_RUN);
	assign cmd.load_out  = load_out;
	assign cmd.err       = err_q;
	assign cmd.transpose = tm_q;
	assign cmd.wr_left   = accept && (func == bvmm_pkg::FUNC_LOAD_LEFT);
	assign cmd.wr_right  = accept && (func == bvmm_pkg::FUNC_LOAD_RIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tm_q        <= 1'b0;
			used_rows_q <= bvmm_pkg::USED_ROWS_RST;
			used_cols_q <= bvmm_pkg::USED_COLS_RST;
			remain_q    <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bvmm_pkg::REG_TRANSPOSE: tm_q <= cfg_wdata[0];
					bvmm_pkg::REG_USED_ROWS: used_rows_q <= cfg_wdata;
					bvmm_pkg::REG_USED_COLS: used_cols_q <= cfg_wdata[bvmm_pkg::USED_COLS_W-1:0];
					default: ;
				endcase
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_compute) begin
						err_q    <= req_err;
						remain_q <= len;
						if (req_err) begin
							state_q <= ST_FINISH;
						end else if (len == '0) begin
							state_q <= ST_DRAIN;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					remain_q <= remain_q - LEN_W'(1);
					if (remain_q == LEN_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!status.busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !status.busy)
		else $error("pipeline busy while accepting input");

	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> !status.busy)
		else $error("result taken before accumulation finished");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result valid raised outside finish");

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (remain_q != '0))
		else $error("issue counter empty in run");

endmodule
